FILE: hdl/fpc_pkg.sv
`default_nettype none
package fpc_pkg;

  // Width of the saturating tick counters; must stay within 8 to 32.
  localparam int TICK_COUNTER_WIDTH = 16;
  localparam int CFG_W = 16;
  localparam int CMP_W = (TICK_COUNTER_WIDTH > CFG_W) ? TICK_COUNTER_WIDTH : CFG_W;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] DOUBLE_PRESS_RESET = CFG_W'(10);
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(20);

  typedef enum logic [1:0] {
    MODE_STANDBY  = 2'd0,
    MODE_TUNING   = 2'd1,
    MODE_SETTINGS = 2'd2,
    MODE_OTHER    = 2'd3
  } tuner_mode_t;

  typedef enum logic {
    REG_DOUBLE_PRESS = 1'b0,
    REG_LONG_PRESS   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] double_press_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } fpc_cfg_t;

  typedef struct packed {
    logic        switch_level;
    tuner_mode_t tuner_mode;
    logic        screen_flag_valid;
    logic        bypass_type_screen;
    logic        bypass_type_valid;
    logic        bypass_type;
  } fpc_item_t;

  typedef struct packed {
    logic single_press;
    logic double_press;
    logic long_press;
    logic bypass_relay;
    logic bypass_type_relay;
  } fpc_result_t;

  function automatic logic [TICK_COUNTER_WIDTH-1:0] sat_inc(
    input logic [TICK_COUNTER_WIDTH-1:0] v
  );
    sat_inc = (&v) ? v : v + TICK_COUNTER_WIDTH'(1);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/fpc_cfg_regs.sv
`default_nettype none
module fpc_cfg_regs
  import fpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output fpc_cfg_t               cfg
);

  logic [CFG_W-1:0] double_press_ticks_r;
  logic [CFG_W-1:0] long_press_ticks_r;
  logic             wr_en;
  reg_index_t       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_t'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_press_ticks_r <= DOUBLE_PRESS_RESET;
      long_press_ticks_r   <= LONG_PRESS_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DOUBLE_PRESS: double_press_ticks_r <= pwdata[CFG_W-1:0];
        REG_LONG_PRESS:   long_press_ticks_r   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DOUBLE_PRESS: prdata = APB_DW'(double_press_ticks_r);
      REG_LONG_PRESS:   prdata = APB_DW'(long_press_ticks_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.double_press_ticks = double_press_ticks_r;
  assign cfg.long_press_ticks   = long_press_ticks_r;

endmodule
`default_nettype wire

FILE: hdl/fpc_classifier.sv
`default_nettype none
module fpc_classifier
  import fpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_en,
  input  wire fpc_item_t item,
  input  wire fpc_cfg_t  cfg,
  output fpc_result_t    result
);

  localparam int TW = TICK_COUNTER_WIDTH;

  logic             previous_level_r, previous_level_nxt;
  logic [1:0]       press_count_r, press_count_nxt;
  logic [TW-1:0]    hold_ticks_r, hold_ticks_nxt;
  logic [TW-1:0]    since_last_press_r, since_last_press_nxt;
  logic             long_fired_r, long_fired_nxt;
  logic [CFG_W-1:0] single_countdown_r, single_countdown_nxt;
  logic             main_relay_r, main_relay_nxt;
  logic             type_relay_r, type_relay_nxt;

  logic ev_single, ev_double, ev_long;
  logic fall, rise;
  logic hold_reached;

  always_comb begin
    previous_level_nxt   = item.switch_level;
    press_count_nxt      = press_count_r;
    long_fired_nxt       = long_fired_r;
    single_countdown_nxt = single_countdown_r;
    main_relay_nxt       = main_relay_r;
    type_relay_nxt       = type_relay_r;
    ev_single            = 1'b0;
    ev_double            = 1'b0;
    ev_long              = 1'b0;

    if (single_countdown_r != '0) begin
      single_countdown_nxt = single_countdown_r - CFG_W'(1);
      if (single_countdown_nxt == '0) begin
        ev_single       = 1'b1;
        press_count_nxt = 2'd0;
      end
    end

    hold_ticks_nxt       = sat_inc(hold_ticks_r);
    since_last_press_nxt = sat_inc(since_last_press_r);

    fall = !item.switch_level && previous_level_r;
    rise = item.switch_level && !previous_level_r;

    if (fall) begin
      if (CMP_W'(since_last_press_nxt) <= CMP_W'(cfg.double_press_ticks)) begin
        if (press_count_nxt != 2'd3) begin
          press_count_nxt = press_count_nxt + 2'd1;
        end
      end else begin
        press_count_nxt = 2'd1;
      end
      since_last_press_nxt = '0;
      hold_ticks_nxt       = '0;
      long_fired_nxt       = 1'b0;
    end

    hold_reached = CMP_W'(hold_ticks_nxt) >= CMP_W'(cfg.long_press_ticks);

    if (!item.switch_level && hold_reached && !long_fired_nxt) begin
      ev_long         = 1'b1;
      long_fired_nxt  = 1'b1;
      press_count_nxt = 2'd0;
    end

    if (rise && !long_fired_nxt) begin
      if (press_count_nxt == 2'd2) begin
        single_countdown_nxt = '0;
        ev_double            = 1'b1;
        press_count_nxt      = 2'd0;
      end else if (press_count_nxt == 2'd1 && !hold_reached) begin
        // In settings mode the single press waits so a second press can follow.
        if (item.tuner_mode == MODE_SETTINGS) begin
          single_countdown_nxt = cfg.double_press_ticks;
        end else begin
          ev_single       = 1'b1;
          press_count_nxt = 2'd0;
        end
      end else begin
        press_count_nxt = 2'd0;
      end
    end

    case (item.tuner_mode)
      MODE_STANDBY:  main_relay_nxt = 1'b0;
      MODE_TUNING:   main_relay_nxt = 1'b1;
      MODE_SETTINGS: begin
        if (item.screen_flag_valid) begin
          main_relay_nxt = !item.bypass_type_screen;
        end
      end
      default: ;
    endcase
    if (item.bypass_type_valid) begin
      type_relay_nxt = item.bypass_type;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      previous_level_r   <= 1'b1;
      press_count_r      <= 2'd0;
      hold_ticks_r       <= '0;
      since_last_press_r <= '1;
      long_fired_r       <= 1'b0;
      single_countdown_r <= '0;
      main_relay_r       <= 1'b0;
      type_relay_r       <= 1'b0;
    end else if (step_en) begin
      previous_level_r   <= previous_level_nxt;
      press_count_r      <= press_count_nxt;
      hold_ticks_r       <= hold_ticks_nxt;
      since_last_press_r <= since_last_press_nxt;
      long_fired_r       <= long_fired_nxt;
      single_countdown_r <= single_countdown_nxt;
      main_relay_r       <= main_relay_nxt;
      type_relay_r       <= type_relay_nxt;
    end
  end

  assign result.single_press      = ev_single;
  assign result.double_press      = ev_double;
  assign result.long_press        = ev_long;
  assign result.bypass_relay      = main_relay_nxt;
  assign result.bypass_type_relay = type_relay_nxt;

endmodule
`default_nettype wire

FILE: hdl/footswitch_press_classifier_core.sv
`default_nettype none
// Footswitch press classifier. Each input transaction carries one footswitch
// sample together with the tuner mode and the bypass-type indications; each
// input transaction produces exactly one result transaction with the single,
// double and long press events of that tick and the two relay levels.
// Both channels use valid/stall: a transaction moves at a rising edge where
// valid is high and stall is low.
// An accepted sample is held in the input register, and the classifier logic
// then writes its result into the result register, from which it is offered.
// Throughput is one transaction per cycle while out_stall stays low; the
// limit is the update of the press state from the input register.
// When out_stall is high and a result is offered, the result register holds, the
// input register holds its sample, and in_stall rises once both are occupied.
// Reset (rst_n low, synchronous) empties both registers, sets the switch to
// open, clears counts, saturates the since-last-press counter and turns both
// relays off. The APB registers return to 10 and 20 ticks and should only be
// written while no transaction is in flight.
module footswitch_press_classifier_core
  import fpc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_switch_level,
  input  wire logic [1:0]        in_tuner_mode,
  input  wire logic              in_screen_flag_valid,
  input  wire logic              in_bypass_type_screen,
  input  wire logic              in_bypass_type_valid,
  input  wire logic              in_bypass_type,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_single_press,
  output logic                   out_double_press,
  output logic                   out_long_press,
  output logic                   out_bypass_relay,
  output logic                   out_bypass_type_relay,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  fpc_cfg_t    cfg;
  fpc_item_t   item_r;
  fpc_result_t step_result;
  fpc_result_t result_r;
  logic        item_valid_r;
  logic        out_valid_r;
  logic        advance;
  logic        load_item;

  fpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held item moves into the result register whenever that register is
  // free or its transaction completes this cycle.
  assign advance   = item_valid_r && (!out_valid_r || !out_stall);
  assign load_item = !item_valid_r || advance;
  assign in_stall  = !load_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (load_item) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item && in_valid) begin
      item_r.switch_level       <= in_switch_level;
      item_r.tuner_mode         <= tuner_mode_t'(in_tuner_mode);
      item_r.screen_flag_valid  <= in_screen_flag_valid;
      item_r.bypass_type_screen <= in_bypass_type_screen;
      item_r.bypass_type_valid  <= in_bypass_type_valid;
      item_r.bypass_type        <= in_bypass_type;
    end
  end

  fpc_classifier u_classifier (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= step_result;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_single_press      = result_r.single_press;
  assign out_double_press      = result_r.double_press;
  assign out_long_press        = result_r.long_press;
  assign out_bypass_relay      = result_r.bypass_relay;
  assign out_bypass_type_relay = result_r.bypass_type_relay;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_valid_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item did not reach the result register");

  a_double_excludes_others: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(result_r.double_press && (result_r.long_press ||
                                                 result_r.single_press)))
    else $error("double press raised together with another press event");

  a_held_item_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && !advance) |=> item_valid_r)
    else $error("pending input item dropped");

endmodule
`default_nettype wire
